@@ rtl/row_run_ratio_pattern_scanner_assert.svh @@
// Assertion macros for the run-ratio scanner, clocked on clk_i, idle in reset
`ifndef ROW_RUN_RATIO_PATTERN_SCANNER_ASSERT_SVH
`define ROW_RUN_RATIO_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication
`define RRRPS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RRRPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rrrps_pkg.sv @@
// Shared constants for the row run-ratio pattern scanner
package rrrps_pkg;

  localparam int OUT_W       = 12;
  localparam int TOL_W       = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd51;
  localparam int RUNS        = 5;
  localparam int POS_DEPTH   = RUNS + 1;
  localparam int CNT_W       = $clog2(POS_DEPTH + 1);
  localparam int RUN_SCALE   = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

@@ rtl/rrrps_pix_if.sv @@
// Pixel channel: one binarised pixel per item
interface rrrps_pix_if;
  logic valid;
  logic ready;
  logic pixel_is_black;
  logic row_last;
  logic frame_first;

  modport source (output valid, output pixel_is_black, output row_last,
                  output frame_first, input ready);
  modport sink (input valid, input pixel_is_black, input row_last,
                input frame_first, output ready);
endinterface

@@ rtl/rrrps_win_if.sv @@
// Window channel: one accepted five-run window per item
interface rrrps_win_if import rrrps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] start_column;
  logic [OUT_W-1:0] row_index;
  logic [OUT_W-1:0] window_length;

  modport source (output valid, output start_column, output row_index,
                  output window_length, input ready);
  modport sink (input valid, input start_column, input row_index,
                input window_length, output ready);
endinterface

@@ rtl/rrrps_front.sv @@
// Front end: column/row tracking, run-edge recording and window candidate extraction
module rrrps_front import rrrps_pkg::*; #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int WW = (RUNS + 2) * CW + RW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rrrps_pix_if.sink     pix_i,
  input  logic          q_ready_i,
  output logic          q_push_o,
  output logic [WW-1:0] q_data_o
);

  typedef logic [POS_DEPTH-1:0][CW-1:0] pos_t;

  function automatic pos_t shift_in(pos_t p, logic [CW-1:0] c);
    return {c, p[POS_DEPTH-1:1]};
  endfunction

  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic             seen_q, seen_d;
  logic             await_q, await_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  pos_t             pos_q, pos_d;

  logic             accept;
  logic             hit;
  logic             ok;
  pos_t             win;
  logic [RW-1:0]    row_cur;
  logic [CW-1:0]    len;
  logic [RUNS-1:0][CW-1:0] runs;

  assign pix_i.ready = q_ready_i;
  assign accept      = pix_i.valid && q_ready_i;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    seen_d  = seen_q;
    await_d = await_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    hit     = 1'b0;
    ok      = 1'b0;
    win     = pos_q;

    if (pix_i.frame_first) begin
      row_d   = '0;
      col_d   = '0;
      seen_d  = 1'b0;
      await_d = 1'b1;
      cnt_d   = '0;
    end
    row_cur = row_d;

    // first black pixel of the row: its column three times
    if (!seen_d && pix_i.pixel_is_black) begin
      seen_d = 1'b1;
      for (int k = 0; k < 3; k++) begin
        pos_d = shift_in(pos_d, col_d);
        if (cnt_d < CNT_W'(POS_DEPTH)) begin
          cnt_d = cnt_d + 1'b1;
        end
      end
    end

    if (seen_d) begin
      if (await_d && !pix_i.pixel_is_black) begin
        ok    = cnt_d >= CNT_W'(RUNS);
        pos_d = shift_in(pos_d, col_d);
        if (cnt_d < CNT_W'(POS_DEPTH)) begin
          cnt_d = cnt_d + 1'b1;
        end
        if (ok) begin
          hit = 1'b1;
          win = pos_d;
        end
        await_d = 1'b0;
      end else if (!await_d && pix_i.pixel_is_black) begin
        pos_d = shift_in(pos_d, col_d);
        if (cnt_d < CNT_W'(POS_DEPTH)) begin
          cnt_d = cnt_d + 1'b1;
        end
        await_d = 1'b1;
      end
    end

    if (pix_i.row_last) begin
      if (seen_d) begin
        ok    = (cnt_d >= CNT_W'(RUNS)) && await_d;
        pos_d = shift_in(pos_d, col_d);
        if (ok) begin
          hit = 1'b1;
          win = pos_d;
        end
      end
      if (row_d == RW'(MAX_ROWS - 1)) begin
        row_d = '0;
      end else begin
        row_d = row_d + 1'b1;
      end
      col_d   = '0;
      seen_d  = 1'b0;
      await_d = 1'b1;
      cnt_d   = '0;
    end else if (col_d < CW'(MAX_COLUMNS - 1)) begin
      col_d = col_d + 1'b1;
    end
  end

  always_comb begin
    for (int j = 0; j < RUNS; j++) begin
      runs[j] = win[j+1] - win[j];
    end
  end

  assign len      = win[POS_DEPTH-1] - win[0];
  assign q_push_o = accept && hit && (len != '0);
  assign q_data_o = {row_cur, win[0], len, runs};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      seen_q  <= 1'b0;
      await_q <= 1'b1;
      cnt_q   <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      seen_q  <= seen_d;
      await_q <= await_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ rtl/rrrps_queue.sv @@
// Short queue of window candidates between front and back end
`include "row_run_ratio_pattern_scanner_assert.svh"
module rrrps_queue import rrrps_pkg::*; #(
  parameter int WIDTH = 96
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] count_q;

  assign ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

  `RRRPS_ASSERT(a_no_overflow, push_i, count_q != QCNT_W'(QUEUE_DEPTH), "push into full queue")
  `RRRPS_ASSERT(a_no_underflow, pop_i, count_q != '0, "pop from empty queue")
  `RRRPS_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == QCNT_W'($past(count_q) + 1'b1), "count lost")

endmodule

@@ rtl/rrrps_back.sv @@
// Back end: run-ratio deviation, tolerance compare and result register
module rrrps_back import rrrps_pkg::*; #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int WW = (RUNS + 2) * CW + RW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [WW-1:0]    q_data_i,
  output logic             q_pop_o,
  input  logic [TOL_W-1:0] tol_i,
  rrrps_win_if.source      win_o
);

  localparam int R5W  = CW + 3;
  localparam int DW   = R5W + 3;
  localparam int LW   = R5W + TOL_W;
  localparam int CMPW = DW + TOL_W;

  logic [CW-1:0]  len, start;
  logic [RW-1:0]  row;
  logic [R5W-1:0] len_x, run5;
  logic [DW-1:0]  dev;
  logic [LW-1:0]  lim;

  logic           s1_valid_q;
  logic [DW-1:0]  dev_q;
  logic [LW-1:0]  lim_q;
  logic [CW-1:0]  start_q, len_q;
  logic [RW-1:0]  row_q;

  logic           out_valid_q;
  logic [CW-1:0]  out_start_q, out_len_q;
  logic [RW-1:0]  out_row_q;

  logic           out_adv, s1_adv, pass;

  assign len   = q_data_i[RUNS*CW +: CW];
  assign start = q_data_i[(RUNS+1)*CW +: CW];
  assign row   = q_data_i[(RUNS+2)*CW +: RW];
  assign len_x = R5W'(len);

  always_comb begin
    dev  = '0;
    run5 = '0;
    for (int j = 0; j < RUNS; j++) begin
      run5 = R5W'(q_data_i[j*CW +: CW]) * R5W'(RUN_SCALE);
      dev  = dev + DW'((run5 >= len_x) ? run5 - len_x : len_x - run5);
    end
  end

  assign lim = LW'(len_x * R5W'(RUN_SCALE)) * LW'(tol_i);

  assign out_adv = !out_valid_q || win_o.ready;
  assign s1_adv  = !s1_valid_q || out_adv;
  assign q_pop_o = q_valid_i && s1_adv;
  assign pass    = {dev_q, {TOL_W{1'b0}}} < CMPW'(lim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= q_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q && pass;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      dev_q   <= dev;
      lim_q   <= lim;
      start_q <= start;
      len_q   <= len;
      row_q   <= row;
    end
    if (out_adv && s1_valid_q) begin
      out_start_q <= start_q;
      out_len_q   <= len_q;
      out_row_q   <= row_q;
    end
  end

  logic [CW+OUT_W-1:0] start_ext, len_ext;
  logic [RW+OUT_W-1:0] row_ext;

  assign start_ext = {{OUT_W{1'b0}}, out_start_q};
  assign len_ext   = {{OUT_W{1'b0}}, out_len_q};
  assign row_ext   = {{OUT_W{1'b0}}, out_row_q};

  assign win_o.valid         = out_valid_q;
  assign win_o.start_column  = start_ext[OUT_W-1:0];
  assign win_o.window_length = len_ext[OUT_W-1:0];
  assign win_o.row_index     = row_ext[OUT_W-1:0];

endmodule

@@ rtl/row_run_ratio_pattern_scanner.sv @@
// Row run-ratio pattern scanner, top level
// Takes one binarised pixel per clock, raster order, and reports every five-run
// window whose run lengths lie close to equal proportion (sum |5r - L| * 256 <
// 5 * L * ratio_tolerance). Sustained rate is one pixel per cycle while the
// queue has room. A result passes through the queue, the deviation/multiply
// stage and the result register before it leaves.
// A two-item queue sits between the pixel front end and the compare back end,
// so output stalls hold pixels back only once it fills. Write ratio_tolerance
// only while the block is idle.
module row_run_ratio_pattern_scanner import rrrps_pkg::*; #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TOL_W-1:0] cfg_wdata_i,
  rrrps_pix_if.sink        pix_i,
  rrrps_win_if.source      win_o
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int WW = (RUNS + 2) * CW + RW;

  logic [TOL_W-1:0] tol_q;
  logic             q_push, q_ready, q_valid, q_pop;
  logic [WW-1:0]    q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  rrrps_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .q_ready_i(q_ready),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  rrrps_queue #(
    .WIDTH(WW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .ready_o(q_ready),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  rrrps_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (q_rdata),
    .q_pop_o  (q_pop),
    .tol_i    (tol_q),
    .win_o    (win_o)
  );

endmodule

@@ bench/tb_row_run_ratio_pattern_scanner.sv @@
// Self-checking bench for the row run-ratio pattern scanner
`timescale 1ns / 100ps

module tb_row_run_ratio_pattern_scanner;
  import rrrps_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int RESET_CYCLES  = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int TOL_ONE       = 1 << TOL_W;
  localparam int MAX_REPORTS   = 100;
  localparam logic [OUT_W-1:0] COL_LAST = '1;

  typedef struct packed {
    logic [OUT_W-1:0] start_column;
    logic [OUT_W-1:0] row_index;
    logic [OUT_W-1:0] window_length;
  } window_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TOL_W-1:0] cfg_wdata_i;

  rrrps_pix_if pix ();
  rrrps_win_if win ();

  row_run_ratio_pattern_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix),
    .win_o       (win)
  );

  // scanner state as the bench sees it
  logic [TOL_W-1:0] tol_m;
  logic [OUT_W-1:0] col_m;
  logic [OUT_W-1:0] row_m;
  bit               seen_black_m;
  bit               await_white_m;
  logic [OUT_W-1:0] pos_m [POS_DEPTH];
  int unsigned      pos_count_m;

  window_t pending_windows [$];
  int      errors = 0;
  int      idle_cycles = 0;
  int      pixels_sent = 0;
  bit      pix_gaps_on = 1'b0;
  bit      win_stalls_on = 1'b0;
  bit      holding_results = 1'b0;
  int      hold_request = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void open_row();
    col_m = '0;
    seen_black_m = 1'b0;
    await_white_m = 1'b1;
    pos_count_m = 0;
  endfunction

  function automatic bit record_column(input logic [OUT_W-1:0] col, input bit odd_index,
                                       output window_t found);
    bit full;
    int len;
    int dev;
    int run5;
    full = pos_count_m >= RUNS;
    for (int j = 0; j < POS_DEPTH - 1; j++) pos_m[j] = pos_m[j + 1];
    pos_m[POS_DEPTH - 1] = col;
    if (pos_count_m < POS_DEPTH) pos_count_m++;
    found = '0;
    if (!(full && odd_index)) return 1'b0;
    len = int'(pos_m[POS_DEPTH - 1]) - int'(pos_m[0]);
    if (len == 0) return 1'b0;
    dev = 0;
    for (int j = 0; j < RUNS; j++) begin
      run5 = RUN_SCALE * (int'(pos_m[j + 1]) - int'(pos_m[j]));
      dev += (run5 >= len) ? run5 - len : len - run5;
    end
    if (dev * TOL_ONE >= RUN_SCALE * len * int'(tol_m)) return 1'b0;
    found.start_column = pos_m[0];
    found.row_index = row_m;
    found.window_length = len[OUT_W-1:0];
    return 1'b1;
  endfunction

  function automatic void scan_pixel(input bit black, input bit last, input bit first);
    window_t found;
    window_t hit;
    bit got;
    logic [OUT_W-1:0] col;
    got = 1'b0;
    hit = '0;
    if (first) begin
      row_m = '0;
      open_row();
    end
    col = col_m;
    // first black column goes in three times
    if (!seen_black_m && black) begin
      seen_black_m = 1'b1;
      repeat (3) void'(record_column(col, 1'b0, found));
    end
    if (seen_black_m) begin
      if (await_white_m && !black) begin
        if (record_column(col, 1'b1, found)) begin
          got = 1'b1;
          hit = found;
        end
        await_white_m = 1'b0;
      end else if (!await_white_m && black) begin
        void'(record_column(col, 1'b0, found));
        await_white_m = 1'b1;
      end
    end
    if (last) begin
      if (seen_black_m) begin
        if (record_column(col, await_white_m, found)) begin
          got = 1'b1;
          hit = found;
        end
      end
      row_m = row_m + 1'b1;
      open_row();
    end else if (col_m != COL_LAST) begin
      col_m = col_m + 1'b1;
    end
    if (got) pending_windows.insert(pending_windows.size(), hit);
  endfunction

  task automatic send_pixel(input bit black, input bit last, input bit first);
    @(negedge clk_i);
    if (pix_gaps_on && $urandom_range(0, 4) == 0) begin
      pix.valid = 1'b0;
      repeat (idle_length()) @(negedge clk_i);
    end
    pix.valid = 1'b1;
    pix.pixel_is_black = black;
    pix.row_last = last;
    pix.frame_first = first;
    do @(posedge clk_i); while (pix.ready !== 1'b1);
    scan_pixel(black, last, first);
    pixels_sent++;
  endtask

  task automatic send_row(input string bits, input bit frame);
    for (int i = 0; i < bits.len(); i++)
      send_pixel(bits[i] == "1", i == bits.len() - 1, frame && i == 0);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    pix.valid = 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tol_m = value;
  endtask

  // mostly run patterns around one unit size, some noise, odd frame restarts
  task automatic send_random_row();
    bit row_bits [$];
    bit colour;
    int lead;
    int unit;
    int runs;
    int len;
    int frame_at;
    frame_at = -1;
    if ($urandom_range(0, 11) == 0) frame_at = 0;
    if ($urandom_range(0, 3) != 0) begin
      lead = $urandom_range(0, 6);
      unit = $urandom_range(1, 4);
      runs = $urandom_range(3, 9);
      colour = 1'b1;
      repeat (lead) row_bits.insert(row_bits.size(), 1'b0);
      repeat (runs) begin
        len = ($urandom_range(0, 4) == 0) ? 3 * unit : unit;
        if ($urandom_range(0, 3) == 0) len = len + int'($urandom_range(0, 2)) - 1;
        if (len < 1) len = 1;
        repeat (len) row_bits.insert(row_bits.size(), colour);
        colour = !colour;
      end
      repeat ($urandom_range(0, 4))
        row_bits.insert(row_bits.size(), bit'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(1, 30))
        row_bits.insert(row_bits.size(), bit'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 29) == 0) frame_at = $urandom_range(0, row_bits.size() - 1);
    foreach (row_bits[i])
      send_pixel(row_bits[i], i == row_bits.size() - 1, i == frame_at);
  endtask

  task automatic test_directed_rows();
    pix_gaps_on = 1'b1;
    win_stalls_on = 1'b1;
    send_row("10101011", 1'b1);
    send_row("0001", 1'b0);
    send_row("00", 1'b0);
    // unfinished row, dropped by the frame start
    send_pixel(1'b1, 1'b0, 1'b0);
    send_pixel(1'b1, 1'b0, 1'b0);
    send_pixel(1'b0, 1'b0, 1'b0);
    send_row("01010", 1'b1);
    send_pixel(1'b1, 1'b1, 1'b1);
    drain_results();
    write_tolerance('1);
    // first window, two empty runs, only passes at a loose tolerance
    send_row("10101011", 1'b0);
    drain_results();
  endtask

  task automatic test_output_stall();
    pix_gaps_on = 1'b0;
    win_stalls_on = 1'b0;
    hold_request = HOLD_CYCLES;
    wait (holding_results);
    for (int i = 0; i < 64; i++) send_pixel(i % 2 == 0, i == 63, 1'b0);
    drain_results();
  endtask

  task automatic test_random_phase(input logic [TOL_W-1:0] tol, input int items,
                                   input bit idling);
    int target;
    write_tolerance(tol);
    pix_gaps_on = idling;
    win_stalls_on = idling;
    target = pixels_sent + items;
    while (pixels_sent < target) send_random_row();
    drain_results();
  endtask

  initial begin : window_sink
    win.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        win.ready = 1'b0;
        holding_results = 1'b1;
        repeat (hold_request) @(negedge clk_i);
        hold_request = 0;
        holding_results = 1'b0;
      end else if (win_stalls_on && $urandom_range(0, 3) == 0) begin
        win.ready = 1'b0;
        repeat (idle_length()) @(negedge clk_i);
      end
      win.ready = 1'b1;
    end
  end

  function automatic void compare_field(input string name, input logic [OUT_W-1:0] want,
                                        input logic [OUT_W-1:0] got);
    if (got !== want) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : window_check
    window_t want;
    if (rst_ni && win.valid === 1'b1 && win.ready === 1'b1) begin
      if (pending_windows.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: window expected none, got col %0d row %0d len %0d", $time,
                   win.start_column, win.row_index, win.window_length);
        errors++;
      end else begin
        want = pending_windows.pop_front();
        compare_field("start_column", want.start_column, win.start_column);
        compare_field("row_index", want.row_index, win.row_index);
        compare_field("window_length", want.window_length, win.window_length);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
        (win.valid === 1'b1 && win.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    pix.valid = 1'b0;
    pix.pixel_is_black = 1'b0;
    pix.row_last = 1'b0;
    pix.frame_first = 1'b0;
    tol_m = TOL_RESET;
    row_m = '0;
    open_row();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_rows();
    test_output_stall();
    test_random_phase(TOL_RESET, 300, 1'b1);
    test_random_phase('0, 250, 1'b1);
    test_random_phase('1, 300, 1'b1);
    test_random_phase(TOL_W'($urandom_range(2, 253)), 300, 1'b0);
    test_random_phase(8'd1, 250, 1'b1);
    test_random_phase(8'd254, 250, 1'b1);
    test_random_phase(TOL_W'($urandom_range(2, 253)), 100, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
